@@ hw/rtl/qpr_pkg.sv @@
// ============================================================================
// qpr_pkg
// Shared widths, component types and pipeline controls for the quaternion
// product and rotation unit.
// ============================================================================
package qpr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 32;
    localparam int COMPC_W   = COMP_W + 1;
    localparam int PROD_W    = COMP_W + COMPC_W;
    localparam int QSUM_W    = PROD_W + 2;

    localparam int IN_DATA_W  = 8 * COMP_W;
    localparam int OUT_DATA_W = 4 * COMP_W;

    localparam logic REQ_PRODUCT = 1'b0;
    localparam logic REQ_ROTATE  = 1'b1;

    typedef struct packed {
        logic signed [COMP_W-1:0] w;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [COMPC_W-1:0] w;
        logic signed [COMPC_W-1:0] x;
        logic signed [COMPC_W-1:0] y;
        logic signed [COMPC_W-1:0] z;
    } t_quatc;

    typedef struct packed {
        logic signed [QSUM_W-1:0] w;
        logic signed [QSUM_W-1:0] x;
        logic signed [QSUM_W-1:0] y;
        logic signed [QSUM_W-1:0] z;
    } t_qsum;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_hp_ctl;

endpackage

@@ hw/rtl/quaternion_product_rotate.sv @@
// ============================================================================
// quaternion_product_rotate
// Fixed-point quaternion product a*b and vector rotation a*(0,v)*conj(a).
// ============================================================================
// Usage:
//   Input stream s_axis: tuser selects the operation (0 product, 1 rotate),
//   tdata carries a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from bit 0 up.
//   Output stream m_axis: tdata carries res_w, res_x, res_y, res_z from
//   bit 0 up, tuser carries the saturation flag.
//   One beat is taken every cycle while s_axis_tready is high. The pipeline
//   has seven register stages: input register, two Hamilton-product units
//   of two stages each (products, then sums), a saturation stage between
//   them and the output register. Product requests bypass the second unit:
//   their saturated first-unit result is carried beside it unchanged.
//   Each stage carries a valid bit and loads when it is empty or when the
//   stage after it loads, so bubbles close up while the receiver stalls and
//   s_axis_tready drops only once every stage holds a beat.
//   Synchronous reset clears all valid bits; no beat is in flight after it.
// ============================================================================
module quaternion_product_rotate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [qpr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // res_w, res_x, res_y, res_z
    output logic [qpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // overflow
    output logic                           m_axis_tuser
);
    import qpr_pkg::*;

    localparam int NSTG = 7;
    localparam logic signed [QSUM_W-1:0] SAT_MAX = QSUM_W'(64'sd2147483647);
    localparam logic signed [QSUM_W-1:0] SAT_MIN = -SAT_MAX - QSUM_W'(1);

    typedef struct packed {
        logic                     ovf;
        logic signed [COMP_W-1:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [QSUM_W-1:0] v);
        t_sat s;
        if (v > SAT_MAX) begin
            s.ovf = 1'b1;
            s.val = {1'b0, {(COMP_W-1){1'b1}}};
        end else if (v < SAT_MIN) begin
            s.ovf = 1'b1;
            s.val = {1'b1, {(COMP_W-1){1'b0}}};
        end else begin
            s.ovf = 1'b0;
            s.val = COMP_W'(v);
        end
        return s;
    endfunction

    logic [NSTG:1] r_v;
    logic [NSTG:1] n_v;
    logic [NSTG:1] en;

    t_quat  in_a;
    t_quatc in_b;

    logic   r_req1, r_req2, r_req3, r_req4, r_req5, r_req6;
    t_quat  r_a1, r_a2, r_a3;
    t_quatc r_b1;
    t_quatc r_c4;
    t_quat  r_t4, r_t5, r_t6;
    logic   r_ovf4, r_ovf5, r_ovf6;
    t_quat  r_res;
    logic   r_ovf7;

    t_qsum   sum_a;
    t_qsum   sum_b;
    t_hp_ctl ctl_a;
    t_hp_ctl ctl_b;

    t_sat   sa_w, sa_x, sa_y, sa_z;
    t_sat   sb_x, sb_y, sb_z;
    t_quat  n_res;
    logic   n_ovf7;

    // Stage enables ripple back from the output register.
    always_comb begin
        en[NSTG] = !r_v[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
        n_v[1] = en[1] ? s_axis_tvalid : r_v[1];
        for (int k = 2; k <= NSTG; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign s_axis_tready = en[1];

    // Unpack; rotation feeds the pure quaternion (0, v).
    always_comb begin
        in_a.w = s_axis_tdata[0*COMP_W +: COMP_W];
        in_a.x = s_axis_tdata[1*COMP_W +: COMP_W];
        in_a.y = s_axis_tdata[2*COMP_W +: COMP_W];
        in_a.z = s_axis_tdata[3*COMP_W +: COMP_W];
        in_b.w = (s_axis_tuser == REQ_ROTATE) ? '0
               : COMPC_W'(signed'(s_axis_tdata[4*COMP_W +: COMP_W]));
        in_b.x = COMPC_W'(signed'(s_axis_tdata[5*COMP_W +: COMP_W]));
        in_b.y = COMPC_W'(signed'(s_axis_tdata[6*COMP_W +: COMP_W]));
        in_b.z = COMPC_W'(signed'(s_axis_tdata[7*COMP_W +: COMP_W]));
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_req1 <= s_axis_tuser;
            r_a1   <= in_a;
            r_b1   <= in_b;
        end
        if (en[2]) begin
            r_req2 <= r_req1;
            r_a2   <= r_a1;
        end
        if (en[3]) begin
            r_req3 <= r_req2;
            r_a3   <= r_a2;
        end
    end

    assign ctl_a.en_mul = en[2];
    assign ctl_a.en_sum = en[3];

    qpr_hprod u_hprod_a (
        .i_clk (i_clk),
        .i_ctl (ctl_a),
        .i_p   (r_a1),
        .i_q   (r_b1),
        .o_sum (sum_a)
    );

    assign sa_w = sat32(sum_a.w);
    assign sa_x = sat32(sum_a.x);
    assign sa_y = sat32(sum_a.y);
    assign sa_z = sat32(sum_a.z);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_req4 <= r_req3;
            r_t4   <= '{w: sa_w.val, x: sa_x.val, y: sa_y.val, z: sa_z.val};
            r_ovf4 <= sa_w.ovf | sa_x.ovf | sa_y.ovf | sa_z.ovf;
            r_c4.w <= COMPC_W'(r_a3.w);
            r_c4.x <= -COMPC_W'(r_a3.x);
            r_c4.y <= -COMPC_W'(r_a3.y);
            r_c4.z <= -COMPC_W'(r_a3.z);
        end
        if (en[5]) begin
            r_req5 <= r_req4;
            r_t5   <= r_t4;
            r_ovf5 <= r_ovf4;
        end
        if (en[6]) begin
            r_req6 <= r_req5;
            r_t6   <= r_t5;
            r_ovf6 <= r_ovf5;
        end
    end

    assign ctl_b.en_mul = en[5];
    assign ctl_b.en_sum = en[6];

    qpr_hprod u_hprod_b (
        .i_clk (i_clk),
        .i_ctl (ctl_b),
        .i_p   (r_t4),
        .i_q   (r_c4),
        .o_sum (sum_b)
    );

    assign sb_x = sat32(sum_b.x);
    assign sb_y = sat32(sum_b.y);
    assign sb_z = sat32(sum_b.z);

    always_comb begin
        if (r_req6 == REQ_ROTATE) begin
            n_res.w = '0;
            n_res.x = sb_x.val;
            n_res.y = sb_y.val;
            n_res.z = sb_z.val;
            n_ovf7  = r_ovf6 | sb_x.ovf | sb_y.ovf | sb_z.ovf;
        end else begin
            n_res  = r_t6;
            n_ovf7 = r_ovf6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_res  <= n_res;
            r_ovf7 <= n_ovf7;
        end
    end

    assign m_axis_tvalid = r_v[NSTG];
    assign m_axis_tdata  = {r_res.z, r_res.y, r_res.x, r_res.w};
    assign m_axis_tuser  = r_ovf7;

endmodule

@@ hw/rtl/qpr_hprod.sv @@
// ============================================================================
// qpr_hprod
// Two-stage Hamilton product p*q: sixteen registered products, then four
// registered sums of floor-shifted terms.
// ============================================================================
module qpr_hprod (
    input  logic            i_clk,
    input  qpr_pkg::t_hp_ctl i_ctl,
    input  qpr_pkg::t_quat  i_p,
    input  qpr_pkg::t_quatc i_q,
    output qpr_pkg::t_qsum  o_sum
);
    import qpr_pkg::*;

    logic signed [COMP_W-1:0]  p_arr [4];
    logic signed [COMPC_W-1:0] q_arr [4];
    logic signed [PROD_W-1:0]  n_prod [4][4];
    logic signed [PROD_W-1:0]  r_prod [4][4];
    logic signed [QSUM_W-1:0]  sh [4][4];
    t_qsum                     n_sum;
    t_qsum                     r_sum;

    always_comb begin
        p_arr[0] = i_p.w;
        p_arr[1] = i_p.x;
        p_arr[2] = i_p.y;
        p_arr[3] = i_p.z;
        q_arr[0] = i_q.w;
        q_arr[1] = i_q.x;
        q_arr[2] = i_q.y;
        q_arr[3] = i_q.z;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_prod[i][j] = PROD_W'(p_arr[i]) * PROD_W'(q_arr[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= n_prod;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                sh[i][j] = QSUM_W'(r_prod[i][j] >>> FRAC_BITS);
            end
        end
        n_sum.w = sh[0][0] - sh[1][1] - sh[2][2] - sh[3][3];
        n_sum.x = sh[0][1] + sh[1][0] + sh[2][3] - sh[3][2];
        n_sum.y = sh[0][2] + sh[2][0] + sh[3][1] - sh[1][3];
        n_sum.z = sh[0][3] + sh[3][0] + sh[1][2] - sh[2][1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

@@ hw/rtl/qpr_checker.sv @@
// ============================================================================
// qpr_checker
// Port-level checks on the quaternion unit: reset, stall behavior and the
// arrival of an unstalled beat at the output.
// ============================================================================
module qpr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [qpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("unstalled beat missing after seven cycles");

endmodule

bind quaternion_product_rotate qpr_checker u_qpr_checker (.*);
